>>> design/sshh_pkg.sv
// package for the space-saving heavy hitter table
// holds entry layout, status codes, sequencer states and shared helpers; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sshh_pkg;

   localparam int ENTRIES_DEF = 256;
   localparam int ID_W        = 32;
   localparam int CNT_W       = 32;
   localparam int SLOT_W      = 8;
   localparam int STATUS_W    = 2;

   localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INSERT  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REPLACE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd3;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] overcount;
   } entry_type;

   // control from the sequencer to the compare unit
   typedef struct packed {
      logic clear;
      logic eval;
      logic first;
   } scan_ctl_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_DRAIN  = 4'b0100,
      S_DECIDE = 4'b1000
   } seq_state_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

`default_nettype wire

>>> design/sshh_scan_unit.sv
// shared compare unit: checks each table entry read back for an id match and
// keeps the running minimum (count, then largest overcount, then lowest slot)
// depends on sshh_pkg
`timescale 1ns / 1ps
`default_nettype none

module sshh_scan_unit #(
   parameter int ENTRIES = sshh_pkg::ENTRIES_DEF,
   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire                         clock,
   input  wire sshh_pkg::scan_ctl_type ctl,
   input  wire [sshh_pkg::ID_W-1:0]    key_id,
   input  wire sshh_pkg::entry_type    rd_entry,
   input  wire [IDX_W-1:0]             rd_idx,
   output logic                        match_found,
   output logic [IDX_W-1:0]            match_idx,
   output sshh_pkg::entry_type         match_entry,
   output logic [IDX_W-1:0]            best_idx,
   output sshh_pkg::entry_type         best_entry
);

   logic                match_ff, match_in;
   logic [IDX_W-1:0]    match_idx_ff;
   sshh_pkg::entry_type match_entry_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   sshh_pkg::entry_type best_entry_ff;
   logic                is_match;
   logic                is_better;

   assign is_match  = ctl.eval && (rd_entry.id == key_id);
   assign is_better = ctl.eval && (ctl.first ||
                      (rd_entry.count < best_entry_ff.count) ||
                      ((rd_entry.count == best_entry_ff.count) &&
                       (rd_entry.overcount > best_entry_ff.overcount)));

   always_comb begin
      match_in = match_ff;
      if (ctl.clear) begin
         match_in = 1'b0;
      end else if (is_match) begin
         match_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      if (is_match) begin
         match_idx_ff   <= rd_idx;
         match_entry_ff <= rd_entry;
      end
      if (is_better) begin
         best_idx_ff   <= rd_idx;
         best_entry_ff <= rd_entry;
      end
   end

   assign match_found = match_ff;
   assign match_idx   = match_idx_ff;
   assign match_entry = match_entry_ff;
   assign best_idx    = best_idx_ff;
   assign best_entry  = best_entry_ff;

endmodule

`default_nettype wire

>>> design/space_saving_heavy_hitter_table.sv
// top level of the space-saving heavy hitter table: entry memory, sequencer, result port
// depends on sshh_pkg and sshh_scan_unit
//
// usage
//   input: raise start with req_flow_id; the word is taken at a clock edge where
//   busy is low. busy stays high while the word is processed.
//   result: one word per input, shown on the rsp_ ports for a single cycle with
//   rsp_valid high. the receiver cannot stall; it must take the word then.
//   flow: a zero id or an empty table skips the scan and goes straight to the
//   decide state. otherwise the occupied slots are read one per cycle from the
//   entry memory through one compare unit, then a drain state follows, then the
//   decide state, which writes the table and registers the result word.
//   busy drops in the cycle the result is shown, so the next word may be
//   accepted right then.
//   reset: synchronous, active high. clears the fill count and sequencer; the
//   entry memory is not cleared since only slots below the fill count are read.
`timescale 1ns / 1ps
`default_nettype none

module space_saving_heavy_hitter_table #(
   parameter int ENTRIES = sshh_pkg::ENTRIES_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   output logic                             busy,
   input  wire [sshh_pkg::ID_W-1:0]         req_flow_id,
   output logic                             rsp_valid,
   output logic [sshh_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sshh_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [sshh_pkg::CNT_W-1:0]       rsp_count,
   output logic [sshh_pkg::CNT_W-1:0]       rsp_overcount,
   output logic [sshh_pkg::ID_W-1:0]        rsp_evicted_id
);

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int FILL_W = $clog2(ENTRIES + 1);

   sshh_pkg::seq_state_type state_ff, state_in;

   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [sshh_pkg::ID_W-1:0] id_ff;
   logic [IDX_W-1:0]          addr_ff, addr_in;
   logic [IDX_W-1:0]          last_addr;
   logic                      rd_valid_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   sshh_pkg::entry_type       rd_data_ff;

   sshh_pkg::entry_type       mem [ENTRIES];
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   sshh_pkg::entry_type       wr_data;

   sshh_pkg::scan_ctl_type    scan_ctl;
   logic                      match_found;
   logic [IDX_W-1:0]          match_idx;
   sshh_pkg::entry_type       match_entry;
   logic [IDX_W-1:0]          best_idx;
   sshh_pkg::entry_type       best_entry;

   logic                      accept;
   logic                      table_full;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sshh_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [sshh_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [sshh_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [sshh_pkg::CNT_W-1:0]      over_ff, over_in;
   logic [sshh_pkg::ID_W-1:0]       evict_ff, evict_in;

   assign accept     = start && (state_ff == sshh_pkg::S_IDLE);
   assign table_full = (fill_ff == FILL_W'(ENTRIES));
   assign last_addr  = IDX_W'(fill_ff - 1'b1);

   // sequencer
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      unique case (state_ff)
         sshh_pkg::S_IDLE: begin
            addr_in = '0;
            if (start) begin
               if ((req_flow_id == '0) || (fill_ff == '0)) begin
                  state_in = sshh_pkg::S_DECIDE;
               end else begin
                  state_in = sshh_pkg::S_SCAN;
               end
            end
         end
         sshh_pkg::S_SCAN: begin
            if (addr_ff == last_addr) begin
               state_in = sshh_pkg::S_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         sshh_pkg::S_DRAIN: begin
            state_in = sshh_pkg::S_DECIDE;
         end
         sshh_pkg::S_DECIDE: begin
            state_in = sshh_pkg::S_IDLE;
         end
         default: begin
            state_in = sshh_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sshh_pkg::S_IDLE;
         fill_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_valid_ff  <= (state_ff == sshh_pkg::S_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      rd_idx_ff <= addr_ff;
      if (accept) begin
         id_ff <= req_flow_id;
      end
      status_ff <= status_in;
      slot_ff   <= slot_in;
      count_ff  <= count_in;
      over_ff   <= over_in;
      evict_ff  <= evict_in;
   end

   // entry memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[addr_ff];
   end

   assign scan_ctl.clear = accept;
   assign scan_ctl.eval  = rd_valid_ff;
   assign scan_ctl.first = (rd_idx_ff == '0);

   sshh_scan_unit #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock       (clock),
      .ctl         (scan_ctl),
      .key_id      (id_ff),
      .rd_entry    (rd_data_ff),
      .rd_idx      (rd_idx_ff),
      .match_found (match_found),
      .match_idx   (match_idx),
      .match_entry (match_entry),
      .best_idx    (best_idx),
      .best_entry  (best_entry)
   );

   // update and result word, all in the decide cycle
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = match_idx;
      wr_data      = match_entry;
      fill_in      = fill_ff;
      rsp_valid_in = 1'b0;
      status_in    = sshh_pkg::ST_REJECT;
      slot_in      = '0;
      count_in     = '0;
      over_in      = '0;
      evict_in     = '0;
      if (state_ff == sshh_pkg::S_DECIDE) begin
         rsp_valid_in = 1'b1;
         priority if (id_ff == '0) begin
            status_in = sshh_pkg::ST_REJECT;
         end else if (match_found) begin
            wr_en             = 1'b1;
            wr_addr           = match_idx;
            wr_data.id        = id_ff;
            wr_data.count     = sshh_pkg::sat_inc(match_entry.count);
            wr_data.overcount = match_entry.overcount;
            status_in         = sshh_pkg::ST_HIT;
            slot_in           = sshh_pkg::SLOT_W'(match_idx);
            count_in          = wr_data.count;
            over_in           = match_entry.overcount;
         end else if (!table_full) begin
            wr_en             = 1'b1;
            wr_addr           = IDX_W'(fill_ff);
            wr_data.id        = id_ff;
            wr_data.count     = sshh_pkg::CNT_W'(1);
            wr_data.overcount = '0;
            fill_in           = fill_ff + 1'b1;
            status_in         = sshh_pkg::ST_INSERT;
            slot_in           = sshh_pkg::SLOT_W'(fill_ff);
            count_in          = sshh_pkg::CNT_W'(1);
         end else begin
            wr_en             = 1'b1;
            wr_addr           = best_idx;
            wr_data.id        = id_ff;
            wr_data.count     = sshh_pkg::sat_inc(best_entry.count);
            wr_data.overcount = best_entry.count;
            status_in         = sshh_pkg::ST_REPLACE;
            slot_in           = sshh_pkg::SLOT_W'(best_idx);
            count_in          = wr_data.count;
            over_in           = best_entry.count;
            evict_in          = best_entry.id;
         end
      end
   end

   assign busy           = (state_ff != sshh_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_count      = count_ff;
   assign rsp_overcount  = over_ff;
   assign rsp_evicted_id = evict_ff;

endmodule

`default_nettype wire

>>> design/sshh_checker.sv
// port-level checker for the space-saving heavy hitter table, bound to the top level
// depends on sshh_pkg and space_saving_heavy_hitter_table
`timescale 1ns / 1ps
`default_nettype none

module sshh_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           start,
   input wire                           busy,
   input wire                           rsp_valid,
   input wire [sshh_pkg::STATUS_W-1:0]  rsp_status,
   input wire [sshh_pkg::SLOT_W-1:0]    rsp_slot,
   input wire [sshh_pkg::CNT_W-1:0]     rsp_count,
   input wire [sshh_pkg::CNT_W-1:0]     rsp_overcount,
   input wire [sshh_pkg::ID_W-1:0]      rsp_evicted_id
);

   // an accepted word always raises busy once it is taken
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // the result word closes the item, so the block is free while it shows
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == sshh_pkg::ST_REJECT)) |->
      ((rsp_slot == '0) && (rsp_count == '0) && (rsp_overcount == '0) &&
       (rsp_evicted_id == '0)))
      else $error("rejected word carries nonzero fields");

   a_evict_only_replace: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != sshh_pkg::ST_REPLACE)) |-> (rsp_evicted_id == '0))
      else $error("evicted id outside a replacement");

   a_insert_fresh: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == sshh_pkg::ST_INSERT)) |->
      ((rsp_count == sshh_pkg::CNT_W'(1)) && (rsp_overcount == '0)))
      else $error("fresh insert with wrong count or overcount");

endmodule

bind space_saving_heavy_hitter_table sshh_checker u_sshh_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_slot       (rsp_slot),
   .rsp_count      (rsp_count),
   .rsp_overcount  (rsp_overcount),
   .rsp_evicted_id (rsp_evicted_id)
);

`default_nettype wire
